/* hdl/nop_pkg.sv */
`timescale 1ns / 1ps

package nop_pkg;

   // Table geometry and field widths.
   localparam int MaxObstacles = 16;
   localparam int SlotWidth    = 4;
   localparam int CountWidth   = 5;
   localparam int PosWidth     = 32;
   localparam int NumHips      = 4;

   localparam logic [CountWidth-1:0] CountReset = 5'd15;
   localparam logic [CountWidth-1:0] CountMax   = 5'd16;
   localparam logic [PosWidth-1:0]   DistMax    = 32'hFFFF_FFFF;

   // Operation codes carried by an input item.
   localparam logic OpStore = 1'b0;
   localparam logic OpQuery = 1'b1;

   typedef logic signed [PosWidth-1:0] pos_type;
   typedef logic [PosWidth-1:0]        dist_type;
   typedef logic [CountWidth-1:0]      index_type;
   typedef logic [SlotWidth-1:0]       slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     store;
      logic     start;
      logic     issue;
      slot_type issue_slot;
      logic     publish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_busy;
      logic rsp_free;
   } status_type;

endpackage

/* hdl/nop_channels.sv */
`timescale 1ns / 1ps

// Request channel: one store or query item.
interface nop_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   nop_pkg::slot_type  slot;
   nop_pkg::pos_type   obstacle_x;
   nop_pkg::pos_type   hip_lf_x;
   nop_pkg::pos_type   hip_rf_x;
   nop_pkg::pos_type   hip_rr_x;
   nop_pkg::pos_type   hip_lr_x;

   modport source (output valid, output operation, output slot, output obstacle_x,
                   output hip_lf_x, output hip_rf_x, output hip_rr_x, output hip_lr_x,
                   input ready);
   modport sink (input valid, input operation, input slot, input obstacle_x,
                 input hip_lf_x, input hip_rf_x, input hip_rr_x, input hip_lr_x,
                 output ready);
endinterface

// Response channel: one result item per query.
interface nop_rsp_if;
   logic                valid;
   logic                ready;
   nop_pkg::index_type  lf_index;
   nop_pkg::index_type  rf_index;
   nop_pkg::index_type  rr_index;
   nop_pkg::index_type  lr_index;
   nop_pkg::dist_type   lf_distance;
   nop_pkg::dist_type   rf_distance;
   nop_pkg::dist_type   rr_distance;
   nop_pkg::dist_type   lr_distance;

   modport source (output valid, output lf_index, output rf_index, output rr_index,
                   output lr_index, output lf_distance, output rf_distance,
                   output rr_distance, output lr_distance, input ready);
   modport sink (input valid, input lf_index, input rf_index, input rr_index,
                 input lr_index, input lf_distance, input rf_distance,
                 input rr_distance, input lr_distance, output ready);
endinterface

/* hdl/nearest_obstacle_per_hip.sv */
`timescale 1ns / 1ps

// Nearest obstacle along x for four hips. A store item writes one signed
// Q16.16 position into one of 16 slots and gives no result. A query item
// scans slots 0 to active_count-1 (at most 16) one slot per cycle, all four
// hips in parallel, through a three-stage read, gap and compare pipeline.
// A query holds the request side from its acceptance until its result is
// published, through the scan, the pipeline drain and any wait while an
// earlier result is still waiting to be taken. The result, held in an
// output register, gives each hip's 1-based nearest slot (first minimum
// wins, 0 when no slot is searched) and its gap (all ones when none). Store
// items are still taken while a result waits. The table is zero after
// reset and active_count resets to 15; write active_count only while the
// block is idle.
module nearest_obstacle_per_hip (
   input  logic                clock,
   input  logic                reset,
   nop_req_if.sink             req_ch,
   nop_rsp_if.source           rsp_ch,
   input  logic                csr_write_enable,
   input  nop_pkg::index_type  csr_write_data
);

   nop_pkg::cmd_type    cmd;
   nop_pkg::status_type status;
   logic [nop_pkg::NumHips-1:0][nop_pkg::PosWidth-1:0]   hip_in;
   logic [nop_pkg::NumHips-1:0][nop_pkg::CountWidth-1:0] rsp_index;
   logic [nop_pkg::NumHips-1:0][nop_pkg::PosWidth-1:0]   rsp_distance;

   assign hip_in[0] = req_ch.hip_lf_x;
   assign hip_in[1] = req_ch.hip_rf_x;
   assign hip_in[2] = req_ch.hip_rr_x;
   assign hip_in[3] = req_ch.hip_lr_x;

   nop_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_operation    (req_ch.operation),
      .req_ready        (req_ch.ready),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .cmd              (cmd)
   );

   nop_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .wr_slot      (req_ch.slot),
      .wr_data      (req_ch.obstacle_x),
      .hip_in       (hip_in),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_index    (rsp_index),
      .rsp_distance (rsp_distance)
   );

   assign rsp_ch.lf_index    = rsp_index[0];
   assign rsp_ch.rf_index    = rsp_index[1];
   assign rsp_ch.rr_index    = rsp_index[2];
   assign rsp_ch.lr_index    = rsp_index[3];
   assign rsp_ch.lf_distance = rsp_distance[0];
   assign rsp_ch.rf_distance = rsp_distance[1];
   assign rsp_ch.rr_distance = rsp_distance[2];
   assign rsp_ch.lr_distance = rsp_distance[3];

   // A query item blocks new items while it runs.
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.operation == nop_pkg::OpQuery)
      |=> !req_ch.ready)
      else $error("request ready right after a query item");

   // Slots are only scanned while no item can be accepted.
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req_ch.ready)
      else $error("scan step while accepting items");

   // A result never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.publish && rsp_ch.valid) |-> rsp_ch.ready)
      else $error("result published over a pending item");

   // Publishing happens only after the compare pipeline has drained.
   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !status.pipe_busy && !$past(cmd.issue))
      else $error("result published before the scan finished");

endmodule

/* hdl/nop_ctrl.sv */
`timescale 1ns / 1ps

module nop_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_operation,
   output logic                   req_ready,
   input  logic                   csr_write_enable,
   input  nop_pkg::index_type     csr_write_data,
   input  nop_pkg::status_type    status,
   output nop_pkg::cmd_type       cmd
);

   nop_pkg::ctrl_state_type state_ff, state_in;
   nop_pkg::index_type      count_ff, count_in;
   nop_pkg::index_type      active_ff, active_in;
   nop_pkg::index_type      limit;

   // Search length register.
   always_comb begin
      active_in = csr_write_enable ? csr_write_data : active_ff;
   end

   // A count above the table depth searches the whole table.
   always_comb begin
      limit = (active_ff > nop_pkg::CountMax) ? nop_pkg::CountMax : active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= nop_pkg::ST_IDLE;
         count_ff  <= '0;
         active_ff <= nop_pkg::CountReset;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         active_ff <= active_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.issue_slot = count_ff[nop_pkg::SlotWidth-1:0];
      case (state_ff)
         nop_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == nop_pkg::OpQuery) begin
                  cmd.start = 1'b1;
                  count_in  = '0;
                  state_in  = nop_pkg::ST_SCAN;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         nop_pkg::ST_SCAN: begin
            // One slot enters the compare pipeline each cycle.
            if (count_ff < limit) begin
               cmd.issue = 1'b1;
               count_in  = count_ff + 5'd1;
            end else begin
               state_in = nop_pkg::ST_DRAIN;
            end
         end
         nop_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = nop_pkg::ST_FINISH;
            end
         end
         nop_pkg::ST_FINISH: begin
            // Wait for the output register to be free.
            if (status.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = nop_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nop_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/nop_datapath.sv */
`timescale 1ns / 1ps

module nop_datapath (
   input  logic                                       clock,
   input  logic                                       reset,
   input  nop_pkg::cmd_type                           cmd,
   output nop_pkg::status_type                        status,
   input  nop_pkg::slot_type                          wr_slot,
   input  nop_pkg::pos_type                           wr_data,
   input  logic [nop_pkg::NumHips-1:0][nop_pkg::PosWidth-1:0] hip_in,
   input  logic                                       rsp_ready,
   output logic                                       rsp_valid,
   output logic [nop_pkg::NumHips-1:0][nop_pkg::CountWidth-1:0] rsp_index,
   output logic [nop_pkg::NumHips-1:0][nop_pkg::PosWidth-1:0]   rsp_distance
);

   nop_pkg::pos_type   table_ff [nop_pkg::MaxObstacles];
   nop_pkg::pos_type   hip_ff   [nop_pkg::NumHips];

   // Stage one: selected table entry.
   nop_pkg::pos_type   pos1_ff;
   nop_pkg::slot_type  slot1_ff;
   logic               valid1_ff;

   // Stage two: absolute gaps.
   nop_pkg::dist_type  dist2_ff [nop_pkg::NumHips];
   nop_pkg::slot_type  slot2_ff;
   logic               valid2_ff;
   nop_pkg::dist_type  gap      [nop_pkg::NumHips];

   // Stage three: running best per hip.
   nop_pkg::dist_type  best_ff  [nop_pkg::NumHips];
   nop_pkg::index_type best_idx_ff [nop_pkg::NumHips];
   logic               found_ff;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   nop_pkg::dist_type  out_dist_ff [nop_pkg::NumHips];
   nop_pkg::index_type out_idx_ff  [nop_pkg::NumHips];

   // Obstacle table, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < nop_pkg::MaxObstacles; i++) begin
            table_ff[i] <= '0;
         end
      end else if (cmd.store) begin
         table_ff[wr_slot] <= wr_data;
      end
   end

   // Hip positions are held for the whole scan.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         for (int h = 0; h < nop_pkg::NumHips; h++) begin
            hip_ff[h] <= hip_in[h];
         end
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= cmd.issue;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pos1_ff  <= table_ff[cmd.issue_slot];
      slot1_ff <= cmd.issue_slot;
      slot2_ff <= slot1_ff;
   end

   // Both differences are formed and the non-negative one kept. The gap of two
   // 32-bit signed values is below 2^32, so it fits in 32 bits and may be all ones.
   always_comb begin
      for (int h = 0; h < nop_pkg::NumHips; h++) begin
         logic signed [nop_pkg::PosWidth:0] diff_a;
         logic signed [nop_pkg::PosWidth:0] diff_b;
         diff_a = {hip_ff[h][nop_pkg::PosWidth-1], hip_ff[h]}
                - {pos1_ff[nop_pkg::PosWidth-1], pos1_ff};
         diff_b = {pos1_ff[nop_pkg::PosWidth-1], pos1_ff}
                - {hip_ff[h][nop_pkg::PosWidth-1], hip_ff[h]};
         gap[h] = diff_a[nop_pkg::PosWidth] ? diff_b[nop_pkg::PosWidth-1:0]
                                            : diff_a[nop_pkg::PosWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int h = 0; h < nop_pkg::NumHips; h++) begin
         dist2_ff[h] <= gap[h];
      end
   end

   // Running minimum; the first slot is always taken, later ones must be nearer.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         found_ff <= 1'b0;
         for (int h = 0; h < nop_pkg::NumHips; h++) begin
            best_ff[h]     <= nop_pkg::DistMax;
            best_idx_ff[h] <= '0;
         end
      end else if (valid2_ff) begin
         found_ff <= 1'b1;
         for (int h = 0; h < nop_pkg::NumHips; h++) begin
            if (!found_ff || (dist2_ff[h] < best_ff[h])) begin
               best_ff[h]     <= dist2_ff[h];
               best_idx_ff[h] <= {1'b0, slot2_ff} + 5'd1;
            end
         end
      end
   end

   // Result register; it frees up when the item is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         for (int h = 0; h < nop_pkg::NumHips; h++) begin
            out_dist_ff[h] <= best_ff[h];
            out_idx_ff[h]  <= best_idx_ff[h];
         end
      end
   end

   always_comb begin
      status.pipe_busy = valid1_ff | valid2_ff;
      status.rsp_free  = !out_valid_ff || rsp_ready;
      rsp_valid        = out_valid_ff;
      for (int h = 0; h < nop_pkg::NumHips; h++) begin
         rsp_index[h]    = out_idx_ff[h];
         rsp_distance[h] = out_dist_ff[h];
      end
   end

endmodule

/* test/nearest_obstacle_per_hip_tb.sv */
`timescale 1ns / 1ps

module nearest_obstacle_per_hip_tb;

   // Covers the longest query with margin.
   localparam int DrainCycles  = 32;
   localparam int LimitCycles  = 300000;
   localparam int RandomPhases = 11;
   localparam int PhaseItems   = 105;

   typedef struct {
      logic              operation;
      nop_pkg::slot_type slot;
      nop_pkg::pos_type  obstacle_x;
      nop_pkg::pos_type  hip_x [nop_pkg::NumHips];
   } request_type;

   typedef struct {
      nop_pkg::index_type nearest [nop_pkg::NumHips];
      nop_pkg::dist_type  gap [nop_pkg::NumHips];
   } nearest_type;

   // Mirror of the obstacle table and the search count, plus the queue of
   // nearest-obstacle answers still owed by the block.
   class obstacle_scoreboard;
      nop_pkg::pos_type   positions [nop_pkg::MaxObstacles];
      nop_pkg::index_type active_count;
      nearest_type        answer_q [$];
      int unsigned        errors;

      function new();
         foreach (positions[i]) positions[i] = '0;
         active_count = nop_pkg::CountReset;
         errors = 0;
      endfunction

      function void set_count(nop_pkg::index_type value);
         active_count = value;
      endfunction

      function int pending();
         return answer_q.size();
      endfunction

      // The gap of two signed 32-bit positions never exceeds 2^32-1.
      function nop_pkg::dist_type gap_between(nop_pkg::pos_type a, nop_pkg::pos_type b);
         logic signed [nop_pkg::PosWidth:0] diff;
         diff = $signed({a[nop_pkg::PosWidth-1], a}) - $signed({b[nop_pkg::PosWidth-1], b});
         if (diff < 0) begin
            diff = -diff;
         end
         return diff[nop_pkg::PosWidth-1:0];
      endfunction

      // Scan the searched slots in order; only a strictly nearer slot replaces
      // the first one taken.
      function void search(nop_pkg::pos_type hip, output nop_pkg::index_type nearest,
                           output nop_pkg::dist_type best);
         int                d;
         nop_pkg::dist_type gap_now;
         d = (active_count > nop_pkg::CountMax) ? nop_pkg::MaxObstacles
                                                : int'(active_count);
         nearest = '0;
         best = nop_pkg::DistMax;
         for (int i = 0; i < d; i++) begin
            gap_now = gap_between(hip, positions[i]);
            if (i == 0 || gap_now < best) begin
               best = gap_now;
               nearest = nop_pkg::index_type'(i + 1);
            end
         end
      endfunction

      function void note_request(request_type item);
         nearest_type answer;
         if (item.operation == nop_pkg::OpStore) begin
            positions[item.slot] = item.obstacle_x;
         end else begin
            for (int h = 0; h < nop_pkg::NumHips; h++) begin
               search(item.hip_x[h], answer.nearest[h], answer.gap[h]);
            end
            answer_q.push_back(answer);
         end
      endfunction

      function void check_answer(nearest_type got);
         nearest_type want;
         string       hip_name [nop_pkg::NumHips];
         hip_name = '{"lf", "rf", "rr", "lr"};
         if (answer_q.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, lf index %0d distance %h",
                     $time, got.nearest[0], got.gap[0]);
            return;
         end
         want = answer_q.pop_front();
         for (int h = 0; h < nop_pkg::NumHips; h++) begin
            if (got.nearest[h] !== want.nearest[h]) begin
               errors++;
               $display("%0t: %s_index expected %0d actual %0d", $time, hip_name[h],
                        want.nearest[h], got.nearest[h]);
            end
            if (got.gap[h] !== want.gap[h]) begin
               errors++;
               $display("%0t: %s_distance expected %h actual %h", $time, hip_name[h],
                        want.gap[h], got.gap[h]);
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   nop_pkg::index_type csr_write_data;
   int                 cycle_count = 0;
   bit                 sender_calm;
   obstacle_scoreboard scoreboard;

   nop_req_if req_ch ();
   nop_rsp_if rsp_ch ();

   nearest_obstacle_per_hip dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LimitCycles) begin
         $display("nearest_obstacle_per_hip_tb: FAIL");
         $finish;
      end
   end

   // Watch both channels and the register port at every edge.
   always @(posedge clock) begin
      request_type item;
      nearest_type got;
      if (!reset) begin
         if (csr_write_enable) begin
            scoreboard.set_count(csr_write_data);
         end
         if (req_ch.valid && req_ch.ready) begin
            item.operation  = req_ch.operation;
            item.slot       = req_ch.slot;
            item.obstacle_x = req_ch.obstacle_x;
            item.hip_x[0]   = req_ch.hip_lf_x;
            item.hip_x[1]   = req_ch.hip_rf_x;
            item.hip_x[2]   = req_ch.hip_rr_x;
            item.hip_x[3]   = req_ch.hip_lr_x;
            scoreboard.note_request(item);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.nearest[0] = rsp_ch.lf_index;
            got.nearest[1] = rsp_ch.rf_index;
            got.nearest[2] = rsp_ch.rr_index;
            got.nearest[3] = rsp_ch.lr_index;
            got.gap[0]     = rsp_ch.lf_distance;
            got.gap[1]     = rsp_ch.rf_distance;
            got.gap[2]     = rsp_ch.rr_distance;
            got.gap[3]     = rsp_ch.lr_distance;
            scoreboard.check_answer(got);
         end
      end
   end

   // Result side: a random stall before each item, with calm stretches.
   initial begin
      int stall;
      int calm;
      calm = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (calm > 0) begin
            calm--;
         end else if ($urandom_range(0, 11) == 0) begin
            calm = $urandom_range(8, 30);
         end
         stall = (calm > 0) ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   function automatic int sender_idle();
      return sender_calm ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic request_type store_item(nop_pkg::slot_type slot, nop_pkg::pos_type x);
      request_type item;
      item.operation  = nop_pkg::OpStore;
      item.slot       = slot;
      item.obstacle_x = x;
      foreach (item.hip_x[h]) item.hip_x[h] = $urandom;
      return item;
   endfunction

   function automatic request_type query_item(nop_pkg::pos_type lf, nop_pkg::pos_type rf,
                                              nop_pkg::pos_type rr, nop_pkg::pos_type lr);
      request_type item;
      item.operation  = nop_pkg::OpQuery;
      item.slot       = nop_pkg::slot_type'($urandom_range(0, 15));
      item.obstacle_x = $urandom;
      item.hip_x      = '{lf, rf, rr, lr};
      return item;
   endfunction

   // Positions mix extremes, a coarse grid that makes ties, values near
   // zero, values near stored obstacles and fully random words.
   function automatic nop_pkg::pos_type pick_position();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1: return nop_pkg::pos_type'((int'($urandom_range(0, 7)) - 4) * 65536);
         2: return nop_pkg::pos_type'(int'($urandom_range(0, 255)) - 128);
         3: return scoreboard.positions[nop_pkg::slot_type'($urandom_range(0, 15))] +
                   nop_pkg::pos_type'(int'($urandom_range(0, 8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(request_type item, int idle);
      if (idle > 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_ch.operation  <= item.operation;
      req_ch.slot       <= item.slot;
      req_ch.obstacle_x <= item.obstacle_x;
      req_ch.hip_lf_x   <= item.hip_x[0];
      req_ch.hip_rf_x   <= item.hip_x[1];
      req_ch.hip_rr_x   <= item.hip_x[2];
      req_ch.hip_lr_x   <= item.hip_x[3];
      req_ch.valid      <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Hold the sender until every owed answer has come back.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (scoreboard.pending() != 0);
   endtask

   task automatic write_active_count(nop_pkg::index_type value);
      settle();
      repeat (DrainCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      nop_pkg::index_type phase_counts [8];
      nop_pkg::index_type count;
      request_type        item;
      int                 items;
      int                 pause_at;

      scoreboard = new();
      phase_counts = '{5'd16, 5'd31, 5'd1, 5'd15, 5'd0, 5'd8, 5'd17, 5'd2};
      sender_calm = 1'b0;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= nop_pkg::OpStore;
      req_ch.slot       <= '0;
      req_ch.obstacle_x <= '0;
      req_ch.hip_lf_x   <= '0;
      req_ch.hip_rf_x   <= '0;
      req_ch.hip_rr_x   <= '0;
      req_ch.hip_lr_x   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fresh table searched with the reset count: every hip lands on slot one.
      send_request(query_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF),
                   sender_idle());
      // Extremes in the first and last slot; the last is outside the reset count.
      send_request(store_item(4'd0, 32'h8000_0000), sender_idle());
      send_request(store_item(4'd15, 32'h7FFF_FFFF), sender_idle());
      send_request(query_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_0000),
                   sender_idle());

      // Full table: the last slot now takes the top hip.
      write_active_count(nop_pkg::CountMax);
      send_request(query_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'hC000_0000),
                   sender_idle());

      // One slot only: it is taken even at the saturated gap.
      write_active_count(5'd1);
      send_request(query_item(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000, 32'h0),
                   sender_idle());

      // No slot searched: zero indices and all-ones distances.
      write_active_count(5'd0);
      send_request(query_item(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678),
                   sender_idle());

      // Count above the table size, and ties where the earlier slot must win.
      write_active_count(5'd31);
      send_request(store_item(4'd2, 32'h0001_0000), sender_idle());
      send_request(store_item(4'd3, 32'h0001_0000), sender_idle());
      send_request(store_item(4'd4, 32'hFFFF_0000), sender_idle());
      send_request(query_item(32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0),
                   sender_idle());
      send_request(store_item(4'd1, 32'h7FFF_FFFF), sender_idle());
      send_request(query_item(32'h7FFF_FFFF, 32'h0000_8000, 32'h8000_0000, 32'h0),
                   sender_idle());

      // Random phases, each with its own search count and pacing.
      for (int p = 0; p < RandomPhases; p++) begin
         count = (p < 8) ? phase_counts[p] : nop_pkg::index_type'($urandom_range(0, 31));
         write_active_count(count);
         sender_calm = ($urandom_range(0, 3) == 0);
         items = (count == 0) ? 40 : PhaseItems;
         pause_at = $urandom_range(10, items - 10);
         for (int k = 0; k < items; k++) begin
            if (k == pause_at) begin
               settle();
            end
            if ($urandom_range(0, 99) < 45) begin
               item = store_item(nop_pkg::slot_type'($urandom_range(0, 15)),
                                 pick_position());
            end else begin
               item = query_item(pick_position(), pick_position(), pick_position(),
                                 pick_position());
            end
            send_request(item, sender_idle());
         end
      end

      settle();
      repeat (DrainCycles) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
         $display("nearest_obstacle_per_hip_tb: PASS");
      end else begin
         $display("nearest_obstacle_per_hip_tb: FAIL");
      end
      $finish;
   end

endmodule
